[sv/mst_pkg.sv]
// ----------------------------------------------------------------------------
// mst_pkg
// Shared sizes, request and status codes, and the scan token that travels
// along the row of storage cells of the multiset table.
// ----------------------------------------------------------------------------
package mst_pkg;

  localparam int CAPACITY   = 64;
  localparam int ELEM_WIDTH = 32;
  localparam int IDX_W      = $clog2(CAPACITY);
  localparam int CNT_W      = $clog2(CAPACITY + 1);

  typedef enum logic [1:0] {
    REQ_ADD    = 2'd0,
    REQ_REMOVE = 2'd1,
    REQ_SEARCH = 2'd2,
    REQ_COUNT  = 2'd3
  } req_t;

  typedef enum logic [1:0] {
    ST_OK        = 2'd0,
    ST_NOT_FOUND = 2'd1,
    ST_FULL      = 2'd2
  } st_t;

  // One lookup in flight; it steps one cell per cycle.
  typedef struct packed {
    logic                  active;
    req_t                  op;
    logic [ELEM_WIDTH-1:0] value;
    logic                  found;
    logic [CNT_W-1:0]      count;
  } token_t;

endpackage

[sv/mst_req_if.sv]
// ----------------------------------------------------------------------------
// mst_req_if
// Request channel of the multiset table: operation code and element value.
// ----------------------------------------------------------------------------
interface mst_req_if import mst_pkg::*; ();

  logic                         valid;
  logic                         ready;
  logic [1:0]                   req_type;
  logic signed [ELEM_WIDTH-1:0] value;

  modport source (output valid, output req_type, output value, input ready);
  modport sink   (input valid, input req_type, input value, output ready);

endinterface

[sv/mst_res_if.sv]
// ----------------------------------------------------------------------------
// mst_res_if
// Result channel of the multiset table: status, match count and occupancy.
// ----------------------------------------------------------------------------
interface mst_res_if import mst_pkg::*; ();

  logic             valid;
  logic             ready;
  logic [1:0]       status;
  logic [CNT_W-1:0] occurrences;
  logic [CNT_W-1:0] occupancy;
  logic             is_empty;

  modport source (output valid, output status, output occurrences, output occupancy,
                  output is_empty, input ready);
  modport sink   (input valid, input status, input occurrences, input occupancy,
                  input is_empty, output ready);

endinterface

[sv/multiset_table_unit.sv]
// ----------------------------------------------------------------------------
// multiset_table_unit
// Fixed-capacity multiset of signed values held in a row of storage cells.
// ----------------------------------------------------------------------------
// An add writes the cell at the fill position; its result goes through the
// pending register to the output register. Remove, search and count send
// a token down the row of CAPACITY cells, one cell per cycle, and their result
// then passes the pending and output registers. One request is in progress at
// a time and the next is taken the cycle after the result moves to the output
// register. Reset empties the table.
// ----------------------------------------------------------------------------
module multiset_table_unit import mst_pkg::*; (
  input  logic clk,
  input  logic rst,
  mst_req_if.sink   req,
  mst_res_if.source res
);

  token_t                tok      [CAPACITY];
  token_t                tok_head;
  logic [ELEM_WIDTH-1:0] cell_data [CAPACITY];
  logic                  cell_shift [CAPACITY];
  logic                  cell_live [CAPACITY];
  logic                  cell_wr [CAPACITY];

  logic [CNT_W-1:0] fill_count;
  logic [CNT_W-1:0] fill_next;
  logic             busy;
  logic             accept;
  logic             add_go;
  req_t             op;

  logic             pend_valid;
  st_t              pend_status;
  logic [CNT_W-1:0] pend_occ;

  logic             out_valid;
  st_t              out_status;
  logic [CNT_W-1:0] out_occ;
  logic [CNT_W-1:0] out_fill;

  token_t last;

  assign op      = req_t'(req.req_type);
  assign accept  = req.valid && req.ready;
  assign req.ready = !busy;
  assign add_go  = accept && (op == REQ_ADD) && (fill_count < CNT_W'(CAPACITY));
  assign last    = tok[CAPACITY-1];

  always_comb begin
    tok_head.active = accept && (op != REQ_ADD);
    tok_head.op     = op;
    tok_head.value  = req.value;
    tok_head.found  = 1'b0;
    tok_head.count  = '0;
  end

  for (genvar j = 0; j < CAPACITY; j++) begin : g_cell
    token_t                t_in;
    logic [ELEM_WIDTH-1:0] r_data;
    logic                  r_shift;

    assign cell_live[j] = CNT_W'(j) < fill_count;
    assign cell_wr[j]   = add_go && (fill_count[IDX_W-1:0] == IDX_W'(j));

    if (j == 0) begin : g_first
      assign t_in = tok_head;
    end else begin : g_rest
      assign t_in = tok[j-1];
    end

    if (j == CAPACITY - 1) begin : g_end
      assign r_data  = cell_data[j];
      assign r_shift = 1'b0;
    end else begin : g_mid
      assign r_data  = cell_data[j+1];
      assign r_shift = cell_shift[j+1];
    end

    mst_cell u_cell (
      .clk         (clk),
      .rst         (rst),
      .live        (cell_live[j]),
      .wr_en       (cell_wr[j]),
      .wr_data     (req.value),
      .tok_in      (t_in),
      .tok_out     (tok[j]),
      .right_data  (r_data),
      .right_shift (r_shift),
      .shift       (cell_shift[j]),
      .data        (cell_data[j])
    );
  end

  always_comb begin
    fill_next = fill_count;
    if (add_go) begin
      fill_next = fill_count + CNT_W'(1);
    end else if (last.active && (last.op == REQ_REMOVE) && last.found) begin
      fill_next = fill_count - CNT_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      fill_count <= '0;
      busy       <= 1'b0;
      pend_valid <= 1'b0;
      out_valid  <= 1'b0;
    end else begin
      fill_count <= fill_next;

      if (accept) begin
        busy <= 1'b1;
      end

      if (accept && (op == REQ_ADD)) begin
        pend_valid  <= 1'b1;
        pend_status <= add_go ? ST_OK : ST_FULL;
        pend_occ    <= '0;
      end else if (last.active) begin
        pend_valid  <= 1'b1;
        pend_status <= (last.op == REQ_COUNT || last.found) ? ST_OK : ST_NOT_FOUND;
        pend_occ    <= (last.op == REQ_COUNT) ? last.count : '0;
      end

      if (pend_valid && (!out_valid || res.ready)) begin
        out_valid  <= 1'b1;
        out_status <= pend_status;
        out_occ    <= pend_occ;
        out_fill   <= fill_count;
        pend_valid <= 1'b0;
        busy       <= 1'b0;
      end else if (res.ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  assign res.valid       = out_valid;
  assign res.status      = out_status;
  assign res.occurrences = out_occ;
  assign res.occupancy   = out_fill;
  assign res.is_empty    = (out_fill == '0);

  a_fill_bound: assert property (@(posedge clk) disable iff (rst)
    fill_count <= CNT_W'(CAPACITY))
    else $error("fill count exceeds capacity");

  a_token_busy: assert property (@(posedge clk) disable iff (rst)
    last.active |-> (busy && !pend_valid))
    else $error("scan finished with no request in progress");

  a_accept_busy: assert property (@(posedge clk) disable iff (rst)
    accept |=> (busy && !req.ready))
    else $error("request taken while another is in progress");

  a_pend_busy: assert property (@(posedge clk) disable iff (rst)
    pend_valid |-> busy)
    else $error("pending result without a request in progress");

endmodule

[sv/mst_cell.sv]
// ----------------------------------------------------------------------------
// mst_cell
// One storage cell of the table. It holds one element, checks the passing
// scan token against it and hands the token on to the next cell. During a
// removal every cell behind the removed entry moves its element one place
// toward the head of the row.
// ----------------------------------------------------------------------------
module mst_cell import mst_pkg::*; (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  live,
  input  logic                  wr_en,
  input  logic [ELEM_WIDTH-1:0] wr_data,
  input  token_t                tok_in,
  output token_t                tok_out,
  input  logic [ELEM_WIDTH-1:0] right_data,
  input  logic                  right_shift,
  output logic                  shift,
  output logic [ELEM_WIDTH-1:0] data
);

  logic match;

  assign match = tok_in.active && live && (data == tok_in.value);

  // A removal whose match lay in an earlier cell pulls this element forward.
  assign shift = tok_in.active && (tok_in.op == REQ_REMOVE) && tok_in.found;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      data <= wr_data;
    end else if (right_shift) begin
      data <= right_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      tok_out.active <= 1'b0;
    end else begin
      tok_out.active <= tok_in.active;
    end
    tok_out.op    <= tok_in.op;
    tok_out.value <= tok_in.value;
    tok_out.found <= tok_in.found | match;
    tok_out.count <= tok_in.count + CNT_W'(match);
  end

endmodule

[verif/mst_table_checker.sv]
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// mst_table_checker
// Watches both channels of the multiset table, keeps its own copy of the
// stored elements, works out the result of every accepted request and
// compares each accepted result with the oldest outstanding one.
// ----------------------------------------------------------------------------
module mst_table_checker import mst_pkg::*; (
  input  logic      clk,
  input  logic      rst,
  mst_req_if        req,
  mst_res_if        res,
  output int        fail_count,
  output int        pending,
  output int        full_seen,
  output int        miss_seen,
  output int        peak_fill
);

  typedef struct {
    req_t                  op;
    logic [ELEM_WIDTH-1:0] value;
    st_t                   status;
    logic [CNT_W-1:0]      occurrences;
    logic [CNT_W-1:0]      occupancy;
    logic                  is_empty;
  } bag_result_t;

  logic [ELEM_WIDTH-1:0] bag_entries [CAPACITY];
  int                    bag_size;
  bag_result_t           awaited_results [$];

  function automatic bag_result_t bag_apply(req_t op, logic [ELEM_WIDTH-1:0] v);
    bag_result_t r;
    int          first_hit;
    r.op          = op;
    r.value       = v;
    r.status      = ST_OK;
    r.occurrences = '0;
    first_hit     = -1;
    for (int i = 0; i < bag_size; i++) begin
      if (bag_entries[i] == v) begin
        if (first_hit < 0) first_hit = i;
        r.occurrences++;
      end
    end
    if (op != REQ_COUNT) r.occurrences = '0;
    case (op)
      REQ_ADD: begin
        if (bag_size >= CAPACITY) begin
          r.status = ST_FULL;
        end else begin
          bag_entries[bag_size] = v;
          bag_size++;
        end
      end
      REQ_REMOVE: begin
        // The last entry moves into the hole left by the removed one.
        if (first_hit >= 0) begin
          bag_entries[first_hit] = bag_entries[bag_size-1];
          bag_size--;
        end else begin
          r.status = ST_NOT_FOUND;
        end
      end
      REQ_SEARCH: begin
        if (first_hit < 0) r.status = ST_NOT_FOUND;
      end
      default: ;
    endcase
    r.occupancy = bag_size[CNT_W-1:0];
    r.is_empty  = (bag_size == 0);
    return r;
  endfunction

  always @(posedge clk) begin
    bag_result_t exp_r;
    if (rst) begin
      bag_size = 0;
      awaited_results.delete();
      fail_count <= 0;
      full_seen  <= 0;
      miss_seen  <= 0;
      peak_fill  <= 0;
    end else begin
      // The result side is handled first: a result taken at this edge belongs
      // to an earlier request, never to one taken at the same edge.
      if (res.valid && res.ready) begin
        if (awaited_results.size() == 0) begin
          if (fail_count < 10)
            $display("%0t: result with nothing outstanding: status %0d occ %0d fill %0d",
                     $realtime, res.status, res.occurrences, res.occupancy);
          fail_count <= fail_count + 1;
        end else begin
          exp_r = awaited_results.pop_front();
          if (res.status !== exp_r.status || res.occurrences !== exp_r.occurrences ||
              res.occupancy !== exp_r.occupancy || res.is_empty !== exp_r.is_empty) begin
            if (fail_count < 10) begin
              $display("%0t: mismatch for %s value %h", $realtime, exp_r.op.name(),
                       exp_r.value);
              $display("  expected status %0d occ %0d fill %0d empty %0b",
                       exp_r.status, exp_r.occurrences, exp_r.occupancy, exp_r.is_empty);
              $display("  actual   status %0d occ %0d fill %0d empty %0b",
                       res.status, res.occurrences, res.occupancy, res.is_empty);
            end
            fail_count <= fail_count + 1;
          end
          if (exp_r.status == ST_FULL) full_seen <= full_seen + 1;
          if (exp_r.status == ST_NOT_FOUND) miss_seen <= miss_seen + 1;
        end
      end
      if (req.valid && req.ready) begin
        awaited_results.push_back(bag_apply(req_t'(req.req_type), req.value));
        if (bag_size > peak_fill) peak_fill <= bag_size;
      end
    end
    pending <= awaited_results.size();
  end

endmodule

[verif/tb.sv]
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb
// Testbench of the multiset table: a directed run over the extremes and the
// corner cases of add, remove, search and count, then phases of random
// requests that fill, hold full, churn and drain the table, with random gaps
// and stalls on both channels and one long stall of the result side.
// ----------------------------------------------------------------------------
module tb;
  import mst_pkg::*;

  localparam int QUIET_LIMIT = 5000;
  localparam int HOLD_CYCLES = 400;
  localparam int PHASE_ITEMS = 100;

  logic clk;
  logic rst;

  mst_req_if req_ch ();
  mst_res_if res_ch ();

  int  fail_count, pending, full_seen, miss_seen, peak_fill;
  int  sent_by_op [4];
  bit  tx_steady, rx_steady, hold_off_req;
  int  hold_offs_done;
  logic [ELEM_WIDTH-1:0] pool [8];

  multiset_table_unit u_dut (
    .clk (clk),
    .rst (rst),
    .req (req_ch),
    .res (res_ch)
  );

  mst_table_checker u_chk (
    .clk        (clk),
    .rst        (rst),
    .req        (req_ch),
    .res        (res_ch),
    .fail_count (fail_count),
    .pending    (pending),
    .full_seen  (full_seen),
    .miss_seen  (miss_seen),
    .peak_fill  (peak_fill)
  );

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  // Mostly short gaps, now and then a long one.
  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 90) return $urandom_range(1, 4);
    return $urandom_range(20, 90);
  endfunction

  function automatic logic [ELEM_WIDTH-1:0] pick_value();
    if ($urandom_range(0, 99) < 85) return pool[$urandom_range(0, 7)];
    return $urandom;
  endfunction

  function automatic logic [ELEM_WIDTH-1:0] fresh_pool_value();
    case ($urandom_range(0, 9))
      0: return 32'h7FFF_FFFF;
      1: return 32'h8000_0000;
      2: return 32'h0000_0000;
      3: return 32'hFFFF_FFFF;
      default: return $urandom;
    endcase
  endfunction

  task automatic offer(input req_t op, input logic [ELEM_WIDTH-1:0] v);
    int gap;
    gap = tx_steady ? 0 : pick_gap();
    if (gap > 0) begin
      req_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    req_ch.valid    <= 1'b1;
    req_ch.req_type <= op;
    req_ch.value    <= v;
    @(posedge clk);
    while (!req_ch.ready) @(posedge clk);
    sent_by_op[op]++;
  endtask

  // Weights are percentages for add, remove and search; count takes the rest.
  task automatic run_phase(input int w_add, input int w_rem, input int w_srch,
                           input bit hold_mid);
    int   r;
    req_t op;
    for (int n = 0; n < PHASE_ITEMS; n++) begin
      if (hold_mid && n == PHASE_ITEMS / 2) hold_off_req = 1'b1;
      r = $urandom_range(0, 99);
      if (r < w_add) op = REQ_ADD;
      else if (r < w_add + w_rem) op = REQ_REMOVE;
      else if (r < w_add + w_rem + w_srch) op = REQ_SEARCH;
      else op = REQ_COUNT;
      offer(op, pick_value());
    end
  endtask

  // Result side: random stalls, steady stretches, and the long hold-off.
  initial begin
    res_ch.ready <= 1'b0;
    forever begin
      @(posedge clk);
      if (rst) begin
        res_ch.ready <= 1'b0;
      end else if (hold_off_req) begin
        res_ch.ready <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk);
        hold_off_req = 1'b0;
        hold_offs_done++;
      end else if (!rx_steady && $urandom_range(0, 3) == 0) begin
        res_ch.ready <= 1'b0;
        repeat (1 + pick_gap()) @(posedge clk);
      end else begin
        res_ch.ready <= 1'b1;
      end
    end
  end

  initial begin
    int quiet;
    quiet = 0;
    forever begin
      @(posedge clk);
      if (rst || (req_ch.valid && req_ch.ready) || (res_ch.valid && res_ch.ready))
        quiet = 0;
      else
        quiet++;
      if (quiet >= QUIET_LIMIT) begin
        $display("Timeout: no item moved for %0d cycles, %0d results outstanding",
                 quiet, pending);
        $display("Simulation FAILED");
        $finish;
      end
    end
  end

  initial begin
    rst             <= 1'b1;
    req_ch.valid    <= 1'b0;
    req_ch.req_type <= REQ_ADD;
    req_ch.value    <= '0;
    tx_steady    = 1'b0;
    rx_steady    = 1'b0;
    hold_off_req = 1'b0;
    for (int i = 0; i < 8; i++) pool[i] = fresh_pool_value();
    repeat (2) @(posedge clk);
    rst <= 1'b0;

    // Directed: empty table, extremes, duplicates, removal from the middle
    // and of the last entry, a count with no match, a miss on remove.
    offer(REQ_SEARCH, 32'h0000_0000);
    offer(REQ_COUNT,  32'h0000_0000);
    offer(REQ_REMOVE, 32'h0000_0000);
    offer(REQ_ADD,    32'h7FFF_FFFF);
    offer(REQ_ADD,    32'h8000_0000);
    offer(REQ_ADD,    32'h0000_0000);
    offer(REQ_ADD,    32'hFFFF_FFFF);
    offer(REQ_ADD,    32'h0000_0000);
    offer(REQ_COUNT,  32'h0000_0000);
    offer(REQ_SEARCH, 32'hFFFF_FFFF);
    offer(REQ_SEARCH, 32'h0000_0001);
    offer(REQ_SEARCH, 32'h8000_0000);
    offer(REQ_REMOVE, 32'hFFFF_FFFF);
    offer(REQ_REMOVE, 32'h0000_0000);
    offer(REQ_REMOVE, 32'h0000_0000);
    offer(REQ_COUNT,  32'h0000_0000);
    offer(REQ_REMOVE, 32'h0000_0005);
    offer(REQ_COUNT,  32'h7FFF_FFFF);
    offer(REQ_REMOVE, 32'h7FFF_FFFF);
    offer(REQ_REMOVE, 32'h8000_0000);
    offer(REQ_SEARCH, 32'h8000_0000);

    // Random: fill up, sit at capacity, churn with a long result stall,
    // drain, churn without any idling, then a mixed finish.
    run_phase(75, 10, 8, 1'b0);
    pool[$urandom_range(0, 7)] = fresh_pool_value();
    run_phase(60, 10, 15, 1'b0);
    pool[$urandom_range(0, 7)] = fresh_pool_value();
    run_phase(30, 30, 20, 1'b1);
    run_phase(10, 70, 10, 1'b0);
    pool[$urandom_range(0, 7)] = fresh_pool_value();
    tx_steady = 1'b1;
    rx_steady = 1'b1;
    run_phase(35, 35, 15, 1'b0);
    tx_steady = 1'b0;
    rx_steady = 1'b0;
    pool[$urandom_range(0, 7)] = fresh_pool_value();
    run_phase(40, 30, 15, 1'b0);
    req_ch.valid <= 1'b0;

    // The checker counts the last request only after this edge.
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (CAPACITY + 8) @(posedge clk);

    $display("Sent %0d adds, %0d removes, %0d searches, %0d counts; %0d long stall(s).",
             sent_by_op[REQ_ADD], sent_by_op[REQ_REMOVE], sent_by_op[REQ_SEARCH],
             sent_by_op[REQ_COUNT], hold_offs_done);
    $display("Saw %0d refused adds, %0d misses, peak occupancy %0d; %0d failure(s).",
             full_seen, miss_seen, peak_fill, fail_count + pending);
    if (fail_count == 0 && pending == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule

[multiset_table_unit.f]
sv/mst_pkg.sv
sv/mst_req_if.sv
sv/mst_res_if.sv
sv/mst_cell.sv
sv/multiset_table_unit.sv
verif/mst_table_checker.sv
verif/tb.sv
